@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/mm3_pkg.sv @@
// Shared constants, queue entry type and helpers for the murmur3 hash block.
// No dependencies.
`default_nettype none

package mm3_pkg;

	localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2 = 32'h1b873593;
	localparam logic [31:0] MM_N  = 32'he6546b64;
	localparam logic [31:0] MM_F1 = 32'h85ebca6b;
	localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

	localparam logic [31:0] SEED_RESET = 32'h12345678;

	// register index of hash_seed
	localparam logic REG_SEED = 1'b0;

	localparam logic [2:0] WORD_BYTES = 3'd4;

	// scrambled word handed from front to back
	typedef struct packed {
		logic [31:0] k;
		logic [2:0]  cnt;
		logic        last;
	} entry_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
		rotl32 = (x << r) | (x >> (32 - r));
	endfunction

endpackage

`default_nettype wire

@@ sv/mm3_front.sv @@
// Front end: accepts key words, masks the tail and runs the two-multiply scramble.
// Uses mm3_pkg; feeds mm3_fifo.
`default_nettype none

module mm3_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic [31:0]    key_word,
	input  wire logic [2:0]     byte_count,
	input  wire logic           last_word,
	output logic                q_push,
	output mm3_pkg::entry_t     q_entry,
	input  wire logic           q_full
);

	logic        v_s1, v_s2;
	logic [31:0] prod_s1;
	logic [2:0]  cnt_s1;
	logic        last_s1;
	logic [31:0] k_s2;
	logic [2:0]  cnt_s2;
	logic        last_s2;

	logic        s1_ready, s2_ready, take, adv1;
	logic [2:0]  cnt_eff;
	logic [31:0] mask, masked;

	assign s2_ready = !v_s2 || !q_full;
	assign s1_ready = !v_s1 || s2_ready;
	assign full     = !s1_ready;
	assign take     = push && s1_ready;
	assign adv1     = v_s1 && s2_ready;

	// body words always count as four bytes; oversize tail counts saturate
	assign cnt_eff = !last_word ? mm3_pkg::WORD_BYTES :
		((byte_count > mm3_pkg::WORD_BYTES) ? mm3_pkg::WORD_BYTES : byte_count);

	always_comb begin
		case (cnt_eff)
			3'd0: mask = 32'h00000000;
			3'd1: mask = 32'h000000ff;
			3'd2: mask = 32'h0000ffff;
			3'd3: mask = 32'h00ffffff;
			default: mask = 32'hffffffff;
		endcase
	end

	assign masked = key_word & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= take || (v_s1 && !s2_ready);
			v_s2 <= adv1 || (v_s2 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= masked * mm3_pkg::MM_C1;
			cnt_s1  <= cnt_eff;
			last_s1 <= last_word;
		end
		if (adv1) begin
			k_s2    <= mm3_pkg::rotl32(prod_s1, 15) * mm3_pkg::MM_C2;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
		end
	end

	assign q_push  = v_s2 && !q_full;
	assign q_entry = '{k: k_s2, cnt: cnt_s2, last: last_s2};

endmodule

`default_nettype wire

@@ sv/mm3_fifo.sv @@
// Short queue of scrambled words between front and back ends.
// Uses mm3_pkg::entry_t.
`default_nettype none

module mm3_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mm3_pkg::entry_t push_entry,
	output logic                 full,
	input  wire logic            pop,
	output mm3_pkg::entry_t      pop_entry,
	output logic                 empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	mm3_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
			if (do_pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

	assign pop_entry = mem_q[rd_q];

endmodule

`default_nettype wire

@@ sv/mm3_back.sv @@
// Back end: folds scrambled words into the running hash, finalizes each key
// and holds the result for the consumer. Uses mm3_pkg; fed by mm3_fifo.
`default_nettype none

module mm3_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_load,
	input  wire logic [31:0]     seed,
	input  wire logic            q_empty,
	input  wire mm3_pkg::entry_t q_entry,
	output logic                 q_pop,
	output logic                 empty,
	input  wire logic            pop,
	output logic [31:0]          hash_value
);

	typedef enum logic [1:0] {
		ST_RUN,
		ST_MIX1,
		ST_MIX2,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [31:0] h_q, len_q, fin_q, out_q;
	logic        out_valid_q;

	logic [31:0] rot, folded, h_new, len_new, mix1, mix2, mix3;
	logic        out_take, out_load;

	assign q_pop    = (state_q == ST_RUN) && !q_empty;
	assign out_take = pop && out_valid_q;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_take);

	assign rot     = mm3_pkg::rotl32(h_q ^ q_entry.k, 13);
	assign folded  = (rot << 2) + rot + mm3_pkg::MM_N;
	// a four-byte final word folds like a body word; shorter tails only XOR in
	assign h_new   = (q_entry.cnt == mm3_pkg::WORD_BYTES) ? folded : (h_q ^ q_entry.k);
	assign len_new = len_q + {29'd0, q_entry.cnt};

	assign mix1 = fin_q ^ (fin_q >> 16);
	assign mix2 = fin_q ^ (fin_q >> 13);
	assign mix3 = fin_q ^ (fin_q >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			h_q         <= mm3_pkg::SEED_RESET;
			len_q       <= '0;
			fin_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_load) begin
				h_q   <= seed;
				len_q <= '0;
			end else if (q_pop) begin
				if (q_entry.last) begin
					fin_q   <= h_new ^ len_new;
					h_q     <= seed;
					len_q   <= '0;
					state_q <= ST_MIX1;
				end else begin
					h_q   <= h_new;
					len_q <= len_new;
				end
			end

			case (state_q)
				ST_MIX1: begin
					fin_q   <= mix1 * mm3_pkg::MM_F1;
					state_q <= ST_MIX2;
				end
				ST_MIX2: begin
					fin_q   <= mix2 * mm3_pkg::MM_F2;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_load)
						state_q <= ST_RUN;
				end
				default: ;
			endcase

			if (out_load) begin
				out_q       <= mix3;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_valid_q;
	assign hash_value = out_q;

endmodule

`default_nettype wire

@@ sv/murmur3_32_hash.sv @@
// Top level of the 32-bit murmur3 hash block: APB seed register plus
// front end, queue and back end. Uses mm3_pkg, mm3_front, mm3_fifo, mm3_back.
//
// Keys stream in as little-endian 32-bit words through a queue-style port
// (push/full); the word flagged last_word carries 0 to 4 bytes and closes
// the key, and its 32-bit hash appears on the result side (empty/pop). The
// front end takes one word per cycle while full is low and scrambles it in a
// two-stage multiply pipeline; the back end folds body words at one per cycle
// while in its run state. Each key end holds the back end through its finish
// sequence: fold, two avalanche multiplies and an output load that waits while
// the previous hash is still unpopped. The hash_seed
// register sits at address 0; writing it restarts any key in progress and
// must only be done while the block is idle.
`default_nettype none

module murmur3_32_hash #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] key_word,
	input  wire logic [2:0]  byte_count,
	input  wire logic        last_word,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      hash_value,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [31:0]     seed_q, seed_next;
	logic            cfg_load;
	logic            q_push, q_full, q_pop, q_empty;
	mm3_pkg::entry_t q_in, q_out;

	assign pready   = 1'b1;
	assign cfg_load = psel && penable && pwrite && pready && (paddr[2] == mm3_pkg::REG_SEED);
	assign prdata   = (paddr[2] == mm3_pkg::REG_SEED) ? seed_q : '0;
	// the value being written takes effect at once on a seed write
	assign seed_next = cfg_load ? pwdata : seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= mm3_pkg::SEED_RESET;
		else if (cfg_load)
			seed_q <= pwdata;
	end

	mm3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.key_word   (key_word),
		.byte_count (byte_count),
		.last_word  (last_word),
		.q_push     (q_push),
		.q_entry    (q_in),
		.q_full     (q_full)
	);

	mm3_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_out),
		.empty      (q_empty)
	);

	mm3_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_load   (cfg_load),
		.seed       (seed_next),
		.q_empty    (q_empty),
		.q_entry    (q_out),
		.q_pop      (q_pop),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule

`default_nettype wire

@@ sv/mm3_checker.sv @@
// Port-level checks for murmur3_32_hash, bound to the top level.
// Uses assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mm3_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        last_word,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [31:0] hash_value,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata
);

	logic [7:0] pend_q;
	logic       key_end, res_xfer, seed_wr, seed_rd;

	assign key_end  = push && !full && last_word;
	assign res_xfer = pop && !empty;
	assign seed_wr  = psel && penable && pwrite && (paddr[2] == mm3_pkg::REG_SEED);
	assign seed_rd  = psel && !pwrite && (paddr[2] == mm3_pkg::REG_SEED);

	// keys closed but whose hash has not been transferred out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else if (key_end && !res_xfer)
			pend_q <= pend_q + 8'd1;
		else if (res_xfer && !key_end)
			pend_q <= pend_q - 8'd1;
	end

	`CHK_NEXT(a_result_holds, !empty && !pop, !empty && $stable(hash_value), "result changed while stalled")
	`CHK_NOW(a_no_extra_result, !empty, pend_q != 8'd0, "result without a closed key")
	`CHK_NOW(a_seed_readback, $past(seed_wr) && seed_rd, prdata == $past(pwdata), "seed readback mismatch")

endmodule

bind murmur3_32_hash mm3_checker u_mm3_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for murmur3_32_hash: streams keys through the push/full port, pops hashes
// through empty/pop and checks each one against an in-bench murmur3 predictor.
// Depends on the RTL only (mm3_pkg, murmur3_32_hash and its submodules).
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] K_MUL1 = 32'hcc9e2d51;
	localparam logic [31:0] K_MUL2 = 32'h1b873593;
	localparam logic [31:0] K_ADD  = 32'he6546b64;
	localparam logic [31:0] K_FIN1 = 32'h85ebca6b;
	localparam logic [31:0] K_FIN2 = 32'hc2b2ae35;
	localparam logic [31:0] SEED_AT_RESET = 32'h12345678;

	localparam logic [2:0] SEED_ADDR  = 3'd0;
	localparam logic [2:0] SPARE_ADDR = 3'd4; // register index 1, unmapped
	localparam int unsigned SEED_INDEX = 0;

	localparam int unsigned DRAIN_CYCLES = 24;
	localparam int unsigned WORD_TARGET  = 1850;
	localparam int unsigned REPORT_LIMIT = 10;

	class hash_scoreboard;
		logic [31:0] seed;
		logic [31:0] run_hash;
		logic [31:0] key_len;
		logic [31:0] expected_hashes[$];
		int unsigned fail_count;

		function new();
			seed = SEED_AT_RESET;
			run_hash = SEED_AT_RESET;
			key_len = '0;
			fail_count = 0;
		endfunction

		function logic [31:0] rot_left(input logic [31:0] x, input int unsigned r);
			return (x << r) | (x >> (32 - r));
		endfunction

		function logic [31:0] scramble_word(input logic [31:0] k);
			logic [31:0] t;
			t = k * K_MUL1;
			t = rot_left(t, 15);
			t = t * K_MUL2;
			return t;
		endfunction

		function logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] k);
			logic [31:0] t;
			t = h ^ scramble_word(k);
			t = rot_left(t, 13);
			return t * 32'd5 + K_ADD;
		endfunction

		function logic [31:0] avalanche(input logic [31:0] h, input logic [31:0] len);
			logic [31:0] t;
			t = h ^ len;
			t = t ^ (t >> 16);
			t = t * K_FIN1;
			t = t ^ (t >> 13);
			t = t * K_FIN2;
			t = t ^ (t >> 16);
			return t;
		endfunction

		function void load_seed(input int unsigned index, input logic [31:0] value);
			if (index == SEED_INDEX) begin
				seed = value;
				run_hash = value;
				key_len = '0;
			end
		endfunction

		// called on every accepted input transfer
		function void note_word(input logic [31:0] w, input logic [2:0] cnt, input logic l);
			logic [31:0] h;
			logic [31:0] mask;
			int unsigned nb;
			if (!l) begin
				// body word: always four bytes, byte_count ignored
				run_hash = fold_word(run_hash, w);
				key_len += 32'd4;
				return;
			end
			nb = (cnt > 3'd4) ? 4 : cnt;
			h = run_hash;
			if (nb == 4) begin
				h = fold_word(h, w);
			end else begin
				mask = (nb == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * nb));
				h ^= scramble_word(w & mask);
			end
			key_len += nb;
			expected_hashes.push_back(avalanche(h, key_len));
			run_hash = seed;
			key_len = '0;
		endfunction

		function void flag(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %08h, got %08h", $realtime, what, exp_v,
					act_v);
		endfunction

		function void check_hash(input logic [31:0] actual);
			logic [31:0] exp_v;
			if (expected_hashes.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: hash %08h popped with none expected", $realtime, actual);
				return;
			end
			exp_v = expected_hashes.pop_front();
			if (actual !== exp_v)
				flag("hash_value", exp_v, actual);
		endfunction

		function int unsigned pending();
			return expected_hashes.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [31:0] key_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last_word = 1'b0;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire logic        full;
	wire logic        empty;
	wire logic [31:0] hash_value;
	wire logic [31:0] prdata;
	wire logic        pready;

	hash_scoreboard sb = new();
	bit calm = 1'b0;
	int unsigned words_sent = 0;

	murmur3_32_hash dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.key_word(key_word),
		.byte_count(byte_count),
		.last_word(last_word),
		.empty(empty),
		.pop(pop),
		.hash_value(hash_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic l);
		while (!calm && $urandom_range(0, 99) < 38) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		key_word <= w;
		byte_count <= cnt;
		last_word <= l;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_word(w, cnt, l);
		words_sent++;
	endtask

	// wait until every hash is out and the back end has gone quiet
	task automatic drain();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.load_seed(addr >> 2, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check_seed();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= SEED_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== sb.seed)
			sb.flag("hash_seed read", sb.seed, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_seed(input logic [31:0] value);
		drain();
		apb_write(SEED_ADDR, value);
		apb_check_seed();
	endtask

	function automatic logic [31:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 32'h0;
		if (r < 6)
			return 32'hffffffff;
		return $urandom;
	endfunction

	task automatic send_key(input int unsigned body, input logic [2:0] tail_cnt);
		logic [2:0] cnt;
		for (int unsigned i = 0; i < body; i++) begin
			cnt = ($urandom_range(0, 99) < 80) ? 3'd4 : 3'($urandom_range(0, 7));
			send_word(pick_word(), cnt, 1'b0);
		end
		send_word(pick_word(), tail_cnt, 1'b1);
	endtask

	function automatic int unsigned pick_body();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 4);
		if (r < 95)
			return $urandom_range(5, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic logic [2:0] pick_tail();
		if ($urandom_range(0, 99) < 85)
			return 3'($urandom_range(0, 4));
		return 3'($urandom_range(5, 7));
	endfunction

	initial begin : result_side
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			pop <= calm || ($urandom_range(0, 99) >= 38);
			@(posedge clk);
			if (pop && !empty)
				sb.check_hash(hash_value);
		end
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset seed, empty key, every tail size, upper garbage masked
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1);
		send_word(32'hffffffff, 3'd2, 1'b1);
		send_word(32'hffffffff, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		// oversized counts saturate to four
		send_word(32'h89abcdef, 3'd5, 1'b1);
		send_word(32'h01234567, 3'd7, 1'b1);
		// body words ignore byte_count
		send_word(32'h00000000, 3'd0, 1'b0);
		send_word(32'hffffffff, 3'd7, 1'b0);
		send_word(32'ha5a55a5a, 3'd2, 1'b1);
		drain();
		apb_check_seed();

		set_seed(32'h0);
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b0);
		send_word(32'h0, 3'd4, 1'b1);

		set_seed(32'hffffffff);
		send_word(32'h12345678, 3'd3, 1'b1);

		// write to an unmapped index must leave the seed alone
		drain();
		apb_write(SPARE_ADDR, 32'hdeadbeef);
		apb_check_seed();
		send_word(32'h0, 3'd1, 1'b1);

		// seed write in the middle of a key drops the partial key
		send_word(32'h11111111, 3'd4, 1'b0);
		send_word(32'h22222222, 3'd4, 1'b0);
		set_seed(32'h9e3779b9);
		send_word(32'h33333333, 3'd4, 1'b1);

		for (int unsigned ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				if ($urandom_range(0, 1) == 1) begin
					for (int unsigned j = $urandom_range(1, 3); j > 0; j--)
						send_word(pick_word(), 3'd4, 1'b0);
				end
				case (ph)
					1: set_seed(32'h0);
					2: set_seed(32'hffffffff);
					default: set_seed($urandom);
				endcase
			end
			calm = (ph == 3);
			while (words_sent < WORD_TARGET * (ph + 1) / 6) begin
				send_key(pick_body(), pick_tail());
				// sender holds off until the block has handed back every hash
				if (ph == 2 && words_sent >= WORD_TARGET / 2 && words_sent < WORD_TARGET / 2 + 8)
					drain();
			end
		end
		calm = 1'b0;

		drain();
		if (sb.fail_count == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+sv
sv/mm3_pkg.sv
sv/mm3_front.sv
sv/mm3_fifo.sv
sv/mm3_back.sv
sv/murmur3_32_hash.sv
sv/mm3_checker.sv
dv/tb_top.sv
